FILE: sv/tdca_pkg.sv
// shared types, constants and helpers of the track dca core
`default_nettype none

package tdca_pkg;

    // default number of fractional bits of the fixed point fields
    localparam int TDCA_FRAC_BITS = 16;
    // fractional bits of the rotation coefficients
    localparam int ROT_BITS = 29;
    // normalized momentum magnitude width, quotient width of the unit ratio
    localparam int MAG_W = 32;
    localparam int QUO_W = 30;
    localparam int NUM_W = MAG_W + QUO_W;

    // per-track payload that travels beside the momentum math
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [30:0]        xx;
        logic [30:0]        yy;
        logic [30:0]        zz;
        logic signed [31:0] xy;
        logic               zero;
        logic               neg_x;
        logic               neg_y;
    } t_trk;

    // clamp to the 32-bit signed range
    function automatic logic signed [31:0] tdca_sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/tdca_isqrt_pipe.sv
// pipelined integer square root, one result bit per stage, with side data
`default_nettype none

module tdca_isqrt_pipe #(
    parameter int W  = 64,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [W-1:0]  i_rad,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [W/2-1:0]     o_root,
    output logic [SW-1:0]      o_side
);
    localparam int H = W / 2;

    logic [W-1:0]  r_rad  [H+1];
    logic [H:0]    r_rem  [H+1];
    logic [H-1:0]  r_root [H+1];
    logic [SW-1:0] r_side [H+1];
    logic          r_v    [H+1];

    // stage zero takes the radicand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // one digit pair per stage: trial subtract of 4*root+1
    for (genvar j = 0; j < H; j++) begin : g_stage
        logic [H+2:0] w_t;
        logic [H+2:0] w_trial;
        logic         w_ge;
        logic [H+2:0] w_diff;

        assign w_t     = {r_rem[j], r_rad[j][W-1:W-2]};
        assign w_trial = {1'b0, r_root[j], 2'b01};
        assign w_ge    = (w_t >= w_trial);
        assign w_diff  = w_t - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j+1]  <= {r_rad[j][W-3:0], 2'b00};
                r_rem[j+1]  <= w_ge ? w_diff[H:0] : w_t[H:0];
                r_root[j+1] <= {r_root[j][H-2:0], w_ge};
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_v[H];
    assign o_root  = r_root[H];
    assign o_side  = r_side[H];

endmodule

`default_nettype wire

FILE: sv/tdca_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, with side data
`default_nettype none

module tdca_div_pipe #(
    parameter int NW = 62,
    parameter int DW = 32,
    parameter int QW = 30,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);
    logic [NW-1:0] r_num  [QW+1];
    logic [DW-1:0] r_den  [QW+1];
    logic [DW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_quo  [QW+1];
    logic [SW-1:0] r_side [QW+1];
    logic          r_v    [QW+1];

    // stage zero: upper numerator bits form the first partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= i_num;
            r_den[0]  <= i_den;
            r_rem[0]  <= DW'(i_num >> QW);
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    // shift in one numerator bit, subtract the divisor when it fits
    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW:0] w_t;
        logic        w_ge;
        logic [DW:0] w_diff;

        assign w_t    = {r_rem[j], r_num[j][QW-1-j]};
        assign w_ge   = (w_t >= {1'b0, r_den[j]});
        assign w_diff = w_t - {1'b0, r_den[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[j+1]  <= r_num[j];
                r_den[j+1]  <= r_den[j];
                r_rem[j+1]  <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
                r_quo[j+1]  <= {r_quo[j][QW-2:0], w_ge};
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_quo[QW];
    assign o_side  = r_side[QW];

endmodule

`default_nettype wire

FILE: sv/tdca_rot.sv
// rotation into the track frame: dca_xy, saturated dca_z, rotated variance
`default_nettype none

module tdca_rot #(
    parameter int FRAC_BITS = tdca_pkg::TDCA_FRAC_BITS,
    parameter int SQ_W      = 2 * ((35 + FRAC_BITS) / 2)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [tdca_pkg::QUO_W-1:0]  i_qx,
    input  wire logic [tdca_pkg::QUO_W-1:0]  i_qy,
    input  wire tdca_pkg::t_trk              i_trk,
    output logic                             o_valid,
    output logic signed [31:0]               o_dca_xy,
    output logic signed [31:0]               o_dca_z,
    output logic [SQ_W-1:0]                  o_var_rad,
    output logic [SQ_W-1:0]                  o_zz_rad
);
    import tdca_pkg::*;

    logic               r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [30:0] r0_c, r0_s;
    t_trk               r0_trk, r1_trk, r2_trk;
    logic signed [63:0] r1_cdx, r1_sdy;
    logic signed [61:0] r1_cc, r1_ss, r1_cs;
    logic signed [64:0] r2_sum;
    logic signed [30:0] r2_cc, r2_ss;
    logic signed [31:0] r2_cs2;
    logic signed [31:0] r3_dxy, r3_dz, r4_dxy, r4_dz;
    logic signed [62:0] r3_mxx, r3_myy;
    logic signed [63:0] r3_mxy;
    logic [30:0]        r3_zz, r4_zz;
    logic signed [65:0] r4_vsum;
    logic signed [31:0] r5_dxy, r5_dz;
    logic [SQ_W-1:0]    r5_var_rad, r5_zz_rad;
    logic signed [36:0] w_var;
    logic signed [30:0] w_qx, w_qy;

    assign w_qx  = $signed({1'b0, i_qx});
    assign w_qy  = $signed({1'b0, i_qy});
    assign w_var = 37'(r4_vsum >>> ROT_BITS);

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // signed unit vector, identity when momentum is zero
            if (i_trk.zero) begin
                r0_c <= 31'sd536870912;
                r0_s <= '0;
            end else begin
                r0_c <= i_trk.neg_y ? -w_qy : w_qy;
                r0_s <= i_trk.neg_x ? -w_qx : w_qx;
            end
            r0_trk <= i_trk;

            // first products
            r1_cdx <= 64'(r0_c * r0_trk.dx);
            r1_sdy <= 64'(r0_s * r0_trk.dy);
            r1_cc  <= r0_c * r0_c;
            r1_ss  <= r0_s * r0_s;
            r1_cs  <= r0_c * r0_s;
            r1_trk <= r0_trk;

            // distance sum and rescaled coefficient products
            r2_sum <= 65'(r1_cdx) + 65'(r1_sdy) + (65'sd1 <<< (ROT_BITS - 1));
            r2_cc  <= 31'(r1_cc >>> ROT_BITS);
            r2_ss  <= 31'(r1_ss >>> ROT_BITS);
            r2_cs2 <= 32'(r1_cs >>> (ROT_BITS - 1));
            r2_trk <= r1_trk;

            // distances and covariance products
            r3_dxy <= tdca_sat32(40'(r2_sum >>> ROT_BITS));
            r3_dz  <= tdca_sat32(40'(r2_trk.dz));
            r3_mxx <= r2_cc * $signed({1'b0, r2_trk.xx});
            r3_myy <= r2_ss * $signed({1'b0, r2_trk.yy});
            r3_mxy <= r2_cs2 * r2_trk.xy;
            r3_zz  <= r2_trk.zz;

            // rotated variance sum
            r4_vsum <= 66'(r3_mxx) + 66'(r3_mxy) + 66'(r3_myy)
                     + (66'sd1 <<< (ROT_BITS - 1));
            r4_dxy  <= r3_dxy;
            r4_dz   <= r3_dz;
            r4_zz   <= r3_zz;

            // radicands for the error roots, negative variance gives zero
            r5_var_rad <= (w_var <= 37'sd0) ? '0 : (SQ_W'(w_var[33:0]) << FRAC_BITS);
            r5_zz_rad  <= SQ_W'(r4_zz) << FRAC_BITS;
            r5_dxy     <= r4_dxy;
            r5_dz      <= r4_dz;
        end
    end

    assign o_valid   = r_v5;
    assign o_dca_xy  = r5_dxy;
    assign o_dca_z   = r5_dz;
    assign o_var_rad = r5_var_rad;
    assign o_zz_rad  = r5_zz_rad;

endmodule

`default_nettype wire

FILE: sv/track_transverse_dca_calc_core.sv
// top level of the track dca core: front end, momentum normalization, output skid
// Computes per track the transverse distance of closest approach to a vertex in the
// frame of the track direction, the longitudinal distance, and the square roots of the
// rotated xy variance and of the z variance, all in fixed point with FRAC_BITS
// fractional bits. One track is accepted every clock cycle and one result leaves per
// track in input order. The pipeline depth is set by the one-bit-per-stage square root
// of the momentum magnitude, the one-bit-per-stage unit-ratio dividers and the error
// square roots. A two-entry output register plus skid decouples the stream ready
// from the downstream ready; the input stalls only while the skid holds a result.
`default_nettype none

module track_transverse_dca_calc_core #(
    parameter int FRAC_BITS = tdca_pkg::TDCA_FRAC_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // track_pos_x, track_pos_y, track_pos_z, track_mom_x, track_mom_y, cov_xx,
    // cov_xy, cov_yy, cov_zz, vertex_x, vertex_y, vertex_z, zero pad
    input  wire logic [383:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // dca_xy, dca_z, dca_xy_error, dca_z_error, zero pad
    output logic [127:0]      o_m_tdata
);
    import tdca_pkg::*;

    localparam int SQ_W = 2 * ((35 + FRAC_BITS) / 2);
    localparam int RT_W = SQ_W / 2;
    localparam int TRK_W = $bits(t_trk);

    logic w_en;

    // input field views
    logic signed [31:0] w_tx, w_ty, w_tz, w_px, w_py, w_vx, w_vy, w_vz, w_xy;
    logic [30:0]        w_xx, w_yy, w_zz;
    assign w_tx = i_s_tdata[31:0];
    assign w_ty = i_s_tdata[63:32];
    assign w_tz = i_s_tdata[95:64];
    assign w_px = i_s_tdata[127:96];
    assign w_py = i_s_tdata[159:128];
    assign w_xx = i_s_tdata[190:160];
    assign w_xy = i_s_tdata[222:191];
    assign w_yy = i_s_tdata[253:223];
    assign w_zz = i_s_tdata[284:254];
    assign w_vx = i_s_tdata[316:285];
    assign w_vy = i_s_tdata[348:317];
    assign w_vz = i_s_tdata[380:349];

    // front end registers
    logic               r_v0, r_v1, r_v2, r_v3;
    t_trk               r0_trk, r1_trk, r2_trk, r3_trk;
    logic [MAG_W-1:0]   r0_ax, r0_ay, r1_ax, r1_ay, r3_ax, r3_ay;
    logic [63:0]        r2_sqx, r2_sqy, r3_ptsq;
    logic [MAG_W-1:0]   w_m;
    logic [4:0]         w_msb, w_k;

    // leading one of the larger magnitude
    always_comb begin
        w_m   = (r0_ax > r0_ay) ? r0_ax : r0_ay;
        w_msb = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (w_m[i]) begin
                w_msb = 5'(i);
            end
        end
        w_k = (w_msb >= 5'd30) ? 5'd0 : 5'd30 - w_msb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // differences to the vertex and momentum magnitudes
            r0_trk.dx    <= 33'(w_tx) - 33'(w_vx);
            r0_trk.dy    <= 33'(w_ty) - 33'(w_vy);
            r0_trk.dz    <= 33'(w_tz) - 33'(w_vz);
            r0_trk.xx    <= w_xx;
            r0_trk.yy    <= w_yy;
            r0_trk.zz    <= w_zz;
            r0_trk.xy    <= w_xy;
            r0_trk.zero  <= (w_px == 32'sd0) && (w_py == 32'sd0);
            r0_trk.neg_x <= w_px[31];
            r0_trk.neg_y <= w_py[31];
            r0_ax        <= w_px[31] ? (~w_px + 32'd1) : w_px;
            r0_ay        <= w_py[31] ? (~w_py + 32'd1) : w_py;

            // normalize so the larger magnitude reaches at least bit 30
            r1_ax  <= r0_ax << w_k;
            r1_ay  <= r0_ay << w_k;
            r1_trk <= r0_trk;

            // squares of the momentum components
            r2_sqx <= 64'(r1_ax) * 64'(r1_ax);
            r2_sqy <= 64'(r1_ay) * 64'(r1_ay);
            r2_trk <= r1_trk;

            r3_ptsq <= r2_sqx + r2_sqy;
            r3_trk  <= r2_trk;
        end
    end

    // carry magnitudes beside the squares
    logic [MAG_W-1:0] r2_ax, r2_ay;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
            r3_ax <= r2_ax;
            r3_ay <= r2_ay;
        end
    end

    // momentum magnitude
    logic                       w_pt_v;
    logic [31:0]                w_pt;
    logic [TRK_W+2*MAG_W-1:0]   w_pt_side;
    t_trk                       w_pt_trk;
    logic [MAG_W-1:0]           w_pt_ax, w_pt_ay;

    tdca_isqrt_pipe #(
        .W  (64),
        .SW (TRK_W + 2 * MAG_W)
    ) u_pt_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_rad   (r3_ptsq),
        .i_side  ({r3_trk, r3_ax, r3_ay}),
        .o_valid (w_pt_v),
        .o_root  (w_pt),
        .o_side  (w_pt_side)
    );

    assign {w_pt_trk, w_pt_ax, w_pt_ay} = w_pt_side;

    // rounded numerators of the unit ratios
    logic             r_v4;
    logic [NUM_W-1:0] r4_nx, r4_ny;
    logic [31:0]      r4_pt;
    t_trk             r4_trk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= w_pt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_nx  <= (NUM_W'(w_pt_ax) << ROT_BITS) + NUM_W'(w_pt >> 1);
            r4_ny  <= (NUM_W'(w_pt_ay) << ROT_BITS) + NUM_W'(w_pt >> 1);
            r4_pt  <= w_pt;
            r4_trk <= w_pt_trk;
        end
    end

    // unit ratios s from px and c from py
    logic             w_div_v, w_div_unused;
    logic [QUO_W-1:0] w_qx, w_qy;
    logic [0:0]       w_qx_side;
    logic [TRK_W-1:0] w_div_side;

    tdca_div_pipe #(
        .NW (NUM_W),
        .DW (MAG_W),
        .QW (QUO_W),
        .SW (1)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_num   (r4_nx),
        .i_den   (r4_pt),
        .i_side  (1'b0),
        .o_valid (w_div_unused),
        .o_quo   (w_qx),
        .o_side  (w_qx_side)
    );

    tdca_div_pipe #(
        .NW (NUM_W),
        .DW (MAG_W),
        .QW (QUO_W),
        .SW (TRK_W)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_num   (r4_ny),
        .i_den   (r4_pt),
        .i_side  (r4_trk),
        .o_valid (w_div_v),
        .o_quo   (w_qy),
        .o_side  (w_div_side)
    );

    // rotation and variance
    logic               w_rot_v;
    logic signed [31:0] w_dxy, w_dz;
    logic [SQ_W-1:0]    w_var_rad, w_zz_rad;

    tdca_rot #(
        .FRAC_BITS (FRAC_BITS),
        .SQ_W      (SQ_W)
    ) u_rot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_div_v),
        .i_qx      (w_qx),
        .i_qy      (w_qy),
        .i_trk     (w_div_side),
        .o_valid   (w_rot_v),
        .o_dca_xy  (w_dxy),
        .o_dca_z   (w_dz),
        .o_var_rad (w_var_rad),
        .o_zz_rad  (w_zz_rad)
    );

    // error roots
    logic            w_err_v, w_zz_v;
    logic [RT_W-1:0] w_xy_root, w_zz_root;
    logic [63:0]     w_err_side;
    logic [0:0]      w_zz_side;

    tdca_isqrt_pipe #(
        .W  (SQ_W),
        .SW (64)
    ) u_xy_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rot_v),
        .i_rad   (w_var_rad),
        .i_side  ({w_dz, w_dxy}),
        .o_valid (w_err_v),
        .o_root  (w_xy_root),
        .o_side  (w_err_side)
    );

    tdca_isqrt_pipe #(
        .W  (SQ_W),
        .SW (1)
    ) u_zz_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rot_v),
        .i_rad   (w_zz_rad),
        .i_side  (1'b0),
        .o_valid (w_zz_v),
        .o_root  (w_zz_root),
        .o_side  (w_zz_side)
    );

    // clamp the roots to the error field range
    logic [63:0]  w_xy_ext, w_zz_ext;
    logic [30:0]  w_xy_err, w_zz_err;
    logic [127:0] w_last;

    assign w_xy_ext = 64'(w_xy_root);
    assign w_zz_ext = 64'(w_zz_root);
    assign w_xy_err = (w_xy_ext > 64'h7FFFFFFF) ? 31'h7FFFFFFF : w_xy_ext[30:0];
    assign w_zz_err = (w_zz_ext > 64'h7FFFFFFF) ? 31'h7FFFFFFF : w_zz_ext[30:0];
    assign w_last   = {2'b00, w_zz_err, w_xy_err, w_err_side};

    // output register with skid entry
    logic         r_out_valid, r_skid_valid;
    logic [127:0] r_out_data, r_skid_data;

    assign w_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_err_v;
            end
        end else if (w_err_v && w_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_last;
        end else if (w_err_v && w_en) begin
            r_skid_data <= w_last;
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // the skid only holds a result behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // the skid fills only on a stalled output transfer
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_tready))
        else $error("skid filled without a stalled output");

    // both error roots leave the pipeline together
    a_roots_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_err_v == w_zz_v)
        else $error("error root pipelines out of step");

    // the divider pipelines stay in step
    a_div_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_v == w_div_unused)
        else $error("divider pipelines out of step");

endmodule

`default_nettype wire

FILE: tb/tdca_checker.sv
// transfer monitor, dca predictor and result scoreboard of the track dca core
`timescale 1ns / 100ps
`default_nettype none

module tdca_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    // track_pos_x, track_pos_y, track_pos_z, track_mom_x, track_mom_y, cov_xx,
    // cov_xy, cov_yy, cov_zz, vertex_x, vertex_y, vertex_z, zero pad
    input  wire logic [383:0] i_s_tdata,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    // dca_xy, dca_z, dca_xy_error, dca_z_error, zero pad
    input  wire logic [127:0] i_m_tdata,
    output int                o_errors,
    output int                o_pending
);

    localparam int FB = tdca_pkg::TDCA_FRAC_BITS;
    localparam int RB = tdca_pkg::ROT_BITS;

    typedef logic signed [127:0] t_wide;

    logic [127:0] dca_expected_q[$];
    int           mismatches;

    // bitwise integer square root
    function automatic logic [127:0] int_sqrt(input logic [127:0] v);
        logic [127:0] res;
        logic [127:0] b;
        res = 0;
        b = 128'd1 << 126;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_wide clamp32(input t_wide v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483648) return -128'sd2147483648;
        return v;
    endfunction

    function automatic logic [30:0] sqrt_err(input t_wide var_v);
        logic [127:0] r;
        if (var_v <= 0) return 31'd0;
        r = int_sqrt(var_v <<< FB);
        if (r > 128'h7FFFFFFF) r = 128'h7FFFFFFF;
        return r[30:0];
    endfunction

    // rounded ratio of a scaled momentum magnitude to pt, q2.29
    function automatic t_wide unit_coef(input logic neg, input t_wide mag, input t_wide pt);
        t_wide r;
        r = ((mag <<< RB) + (pt >>> 1)) / pt;
        return neg ? -r : r;
    endfunction

    function automatic logic [127:0] predict_dca(input logic [383:0] d);
        t_wide tx, ty, tz, px, py, xx, xy, yy, zz, vx, vy, vz;
        t_wide dx, dy, dz, c, s, ax, ay, m, pt, cc, ss, cs2, var_v, dxy;
        t_wide dxy_c, dz_c;
        logic [127:0] res;
        tx = t_wide'($signed(d[31:0]));
        ty = t_wide'($signed(d[63:32]));
        tz = t_wide'($signed(d[95:64]));
        px = t_wide'($signed(d[127:96]));
        py = t_wide'($signed(d[159:128]));
        xx = {97'd0, d[190:160]};
        xy = t_wide'($signed(d[222:191]));
        yy = {97'd0, d[253:223]};
        zz = {97'd0, d[284:254]};
        vx = t_wide'($signed(d[316:285]));
        vy = t_wide'($signed(d[348:317]));
        vz = t_wide'($signed(d[380:349]));
        dx = tx - vx;
        dy = ty - vy;
        dz = tz - vz;
        // zero momentum: identity rotation
        if (px == 0 && py == 0) begin
            c = t_wide'(1) <<< RB;
            s = 0;
        end else begin
            ax = (px < 0) ? -px : px;
            ay = (py < 0) ? -py : py;
            m = (ax > ay) ? ax : ay;
            while (m < (t_wide'(1) <<< 30)) begin
                m = m <<< 1;
                ax = ax <<< 1;
                ay = ay <<< 1;
            end
            pt = $signed(int_sqrt(ax * ax + ay * ay));
            c = unit_coef(py < 0, ay, pt);
            s = unit_coef(px < 0, ax, pt);
        end
        dxy = (c * dx + s * dy + (t_wide'(1) <<< (RB - 1))) >>> RB;
        cc = (c * c) >>> RB;
        ss = (s * s) >>> RB;
        cs2 = (2 * c * s) >>> RB;
        var_v = (cc * xx + cs2 * xy + ss * yy + (t_wide'(1) <<< (RB - 1))) >>> RB;
        dxy_c = clamp32(dxy);
        dz_c = clamp32(dz);
        res = '0;
        res[31:0] = dxy_c[31:0];
        res[63:32] = dz_c[31:0];
        res[94:64] = sqrt_err(var_v);
        res[125:95] = sqrt_err(zz);
        return res;
    endfunction

    // watch both channels, predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        logic [127:0] want;
        logic [127:0] fresh;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                fresh = predict_dca(i_s_tdata);
                dca_expected_q = {dca_expected_q, fresh};
            end
            if (i_m_tvalid && i_m_tready) begin
                if (dca_expected_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("unexpected result transfer: %h", i_m_tdata);
                    end
                end else begin
                    want = dca_expected_q.pop_front();
                    if (want[31:0] !== i_m_tdata[31:0] || want[63:32] !== i_m_tdata[63:32] ||
                        want[94:64] !== i_m_tdata[94:64] ||
                        want[125:95] !== i_m_tdata[125:95] ||
                        i_m_tdata[127:126] !== 2'b00) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("dca mismatch: xy exp %h got %h, z exp %h got %h",
                                     want[31:0], i_m_tdata[31:0],
                                     want[63:32], i_m_tdata[63:32]);
                            $display("  xy_err exp %h got %h, z_err exp %h got %h",
                                     want[94:64], i_m_tdata[94:64],
                                     want[125:95], i_m_tdata[125:95]);
                        end
                    end
                end
            end
        end
        o_errors <= mismatches;
        o_pending <= dca_expected_q.size();
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// stimulus, stall patterns and verdict for the track dca core
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    localparam int N_RANDOM = 2000;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [127:0] m_tdata;
    int           errors;
    int           pending;
    int           cycles = 0;
    int           stall_mode = 0;

    track_transverse_dca_calc_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    tdca_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_m_tdata (m_tdata),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // pack one track into the input word
    function automatic logic [383:0] pack_track(
        input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] tz,
        input logic [31:0] px, input logic [31:0] py,
        input logic [30:0] xx, input logic [31:0] xy, input logic [30:0] yy,
        input logic [30:0] zz,
        input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
        return {3'b000, vz, vy, vx, zz, yy, xy, xx, py, px, tz, ty, tx};
    endfunction

    // random value, often of small magnitude
    function automatic logic [31:0] rand_field();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $signed($urandom_range(2000000)) - 1000000;
            2: return $signed($urandom_range(200)) - 100;
            default: return {1'($urandom_range(1)), 31'd0} | ($urandom() >> $urandom_range(31));
        endcase
    endfunction

    function automatic logic [383:0] rand_track();
        logic [31:0] px;
        logic [31:0] py;
        px = rand_field();
        py = rand_field();
        if ($urandom_range(15) == 0) begin
            px = 0;
            py = 0;
        end else if ($urandom_range(15) == 0) begin
            px = 0;
        end
        return pack_track(rand_field(), rand_field(), rand_field(), px, py,
                          31'(rand_field()), rand_field(), 31'(rand_field()),
                          31'(rand_field()),
                          rand_field(), rand_field(), rand_field());
    endfunction

    // present one item and hold it until the transfer
    task automatic send_track(input logic [383:0] d);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // receiver stall pattern, from a randomly redrawn mode
    always @(posedge i_clk) begin
        if (cycles % 700 == 0) stall_mode <= $urandom_range(3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(3) != 0);
            2: m_tready <= ((cycles / 9) % 3 != 0);
            default: m_tready <= ($urandom_range(1) != 0);
        endcase
    end

    // run length guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** track_transverse_dca_calc_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int burst;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero momentum, extremes, negative variance, saturation
        send_track(pack_track(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_track(pack_track(32'h00010000, 32'h00020000, 32'h00030000, 0, 0,
                              31'h00010000, 0, 31'h00040000, 31'h00090000, 0, 0, 0));
        send_track(pack_track(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0,
                              31'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                              32'h80000000, 32'h80000000, 32'h80000000));
        send_track(pack_track(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 31'h7FFFFFFF, 32'h80000000,
                              31'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_track(pack_track(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              0, 32'h80000000, 0, 1, 32'h80000000, 32'h7FFFFFFF, 0));
        send_track(pack_track(32'h00050000, 32'hFFFB0000, 32'h00010000, 32'h00010000,
                              32'h00010000, 31'd10, 32'h80000000, 31'd10, 31'd1,
                              0, 0, 32'h00020000));
        send_track(pack_track(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1, 0,
                              31'h00010000, 0, 31'h00010000, 31'h00010000, 0, 0, 0));
        send_track(pack_track(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 0, 1,
                              31'h00010000, 0, 31'h00010000, 31'h00010000, 0, 0, 0));
        send_track(pack_track(32'h00100000, 32'h00100000, 0, 32'hFFFFFFFF, 0,
                              31'h00020000, 32'hFFFF0000, 31'h00030000, 0, 0, 0, 0));
        send_track(pack_track(32'h00100000, 32'hFFF00000, 0, 0, 32'h80000000,
                              31'h00020000, 32'h00010000, 31'h00030000, 31'h7FFFFFFF,
                              0, 0, 0));
        send_track(pack_track(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00030000,
                              32'hFFFC0000, 31'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                              31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_track(pack_track(32'h7FFFFFFF, 0, 32'h80000000, 32'h00000003, 32'h00000004,
                              0, 0, 0, 0, 32'hFFFFFFFF, 0, 32'h00000001));

        // hold off until every expected result is back
        idle_gap(1);
        while (pending != 0) @(posedge i_clk);

        // random bursts with random gaps
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, ($urandom_range(3) == 0) ? 60 : 8);
            for (int k = 0; k < burst && n < N_RANDOM; k++) begin
                send_track(rand_track());
                n++;
            end
            idle_gap(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12));
            if (n > N_RANDOM / 2 && n - burst <= N_RANDOM / 2) begin
                idle_gap(1);
                while (pending != 0) @(posedge i_clk);
            end
        end
        idle_gap(1);

        // drain, then allow for the pipeline depth
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("** track_transverse_dca_calc_core: PASSED **");
        end else begin
            $display("** track_transverse_dca_calc_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
